### src/pfac_pkg.sv
// ----------------------------------------------------------------------------
// pfac_pkg
// Shared widths, types and codes of the failureless trie matcher.
// ----------------------------------------------------------------------------
package pfac_pkg;

  localparam int unsigned PtrW    = 10;
  localparam int unsigned NumCols = 256;
  localparam int unsigned ColW    = $clog2(NumCols);
  localparam int unsigned PosW    = 32;
  // A lookup row can be the start row, which is one past the widest pattern count.
  localparam int unsigned RowReqW = PtrW + 1;

  typedef logic [PtrW-1:0]    ptr_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [RowReqW-1:0] row_req_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  // Request from the sequencer to the transition table.
  typedef struct packed {
    logic     wr_en;
    ptr_t     wr_row;
    col_t     wr_col;
    ptr_t     wr_value;
    logic     rd_en;
    row_req_t rd_row;
    col_t     rd_col;
  } tbl_req_t;

endpackage

### src/pfac_multi_pattern_matcher.sv
// ----------------------------------------------------------------------------
// pfac_multi_pattern_matcher
// Failureless trie matcher that walks one thread per table lookup.
// ----------------------------------------------------------------------------
// After reset the block sweeps all min(TABLE_ROWS, 1024) * 256 entries of
// the transition table to zero, one entry per cycle, and holds in_stall_o
// high meanwhile; pattern_count writes are taken at any time.
// A table write item leaves in_stall_o low. A scan item holds in_stall_o
// high from when it is taken until its walk is done: one lookup for each of
// the L live threads and one for the new thread, then the drain state waits
// for the last lookup to return and for room to pass on the held match. L is
// the number of live threads, at most MAX_PATTERN_LENGTH; a thread that has
// reached the length limit still gets its lookup before it is dropped. The
// single read port of the table serves one lookup per cycle while the walk
// is not held, first the live threads oldest first and then the new thread
// from the start row. Output stalls hold the walk when a match is found while
// the held match cannot move on to a full output register, and hold the end
// of the byte when the held match must leave while the output is full. Each
// match item carries the start position and the pattern-end row; last_match
// marks the final match item that a text byte causes. Bytes that cause no match give no item.
module pfac_multi_pattern_matcher #(
  parameter int unsigned TABLE_ROWS         = 1024,
  parameter int unsigned MAX_PATTERN_LENGTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pfac_pkg::PtrW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [pfac_pkg::PtrW-1:0] entry_row_i,
  input  logic [pfac_pkg::ColW-1:0] entry_column_i,
  input  logic [pfac_pkg::PtrW-1:0] entry_value_i,
  input  logic [pfac_pkg::ColW-1:0] text_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pfac_pkg::PosW-1:0] match_start_o,
  output logic [pfac_pkg::PtrW-1:0] match_row_o,
  output logic                      last_match_o
);

  // Thread slot index and thread count widths.
  localparam int unsigned IdxW = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
  localparam int unsigned CntW = $clog2(MAX_PATTERN_LENGTH + 1);

  // Sequencer states.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]          state_q, state_d;
  pfac_pkg::ptr_t      pattern_count_q;
  pfac_pkg::pos_t      pos_q, pos_d;
  logic [CntW-1:0]     live_count_q, live_count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     kept_q, kept_d;
  pfac_pkg::col_t      byte_q;
  logic                last_q;

  // Thread slots. Live threads always fill slots 0 .. live_count_q - 1 in
  // ascending start order, so the slot count replaces per-slot live bits.
  pfac_pkg::ptr_t      thr_row_q   [MAX_PATTERN_LENGTH];
  pfac_pkg::pos_t      thr_start_q [MAX_PATTERN_LENGTH];

  // Lookup stage: the thread whose table read is in flight.
  logic                s1_valid_q, s1_valid_d;
  logic                s1_skip_q;
  pfac_pkg::pos_t      s1_start_q;

  // The newest match is held back until it is known whether another follows.
  logic                pend_valid_q, pend_valid_d;
  pfac_pkg::pos_t      pend_start_q, pend_start_d;
  pfac_pkg::ptr_t      pend_row_q, pend_row_d;

  logic                out_valid_q, out_valid_d;
  pfac_pkg::pos_t      out_start_q, out_start_d;
  pfac_pkg::ptr_t      out_row_q, out_row_d;
  logic                out_last_q, out_last_d;

  pfac_pkg::tbl_req_t  tbl_req;
  pfac_pkg::ptr_t      tbl_rd_data;
  logic                tbl_ready;

  logic                in_accept;
  logic                is_spawn;
  pfac_pkg::ptr_t      sel_row;
  pfac_pkg::pos_t      sel_start;
  pfac_pkg::pos_t      sel_age;
  logic                sel_drop;
  logic                issue;
  pfac_pkg::ptr_t      s1_next;
  logic                s1_hit;
  logic                s1_emit;
  logic                out_free;
  logic                freeze;
  logic                finish;
  logic                thr_we;

  assign in_stall_o = !((state_q == StIdle) && tbl_ready);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Slot select for the lookup about to be issued. The slot past the live
  // threads stands for the new thread that starts at the current byte.
  assign is_spawn  = (idx_q == live_count_q);
  assign sel_row   = thr_row_q[idx_q[IdxW-1:0]];
  assign sel_start = is_spawn ? pos_q : thr_start_q[idx_q[IdxW-1:0]];
  // A thread that has already consumed MAX_PATTERN_LENGTH bytes is dropped.
  assign sel_age   = pos_q - sel_start;
  assign sel_drop  = !is_spawn && (sel_age >= pfac_pkg::pos_t'(MAX_PATTERN_LENGTH));

  // Result of the lookup in flight, from the registered table read.
  assign s1_next  = s1_skip_q ? '0 : tbl_rd_data;
  assign s1_hit   = s1_valid_q && (s1_next != '0);
  assign s1_emit  = s1_hit && (s1_next <= pattern_count_q);
  assign out_free = !out_valid_q || !out_stall_i;
  // A second match with the output still full holds the whole walk.
  assign freeze   = s1_emit && pend_valid_q && !out_free;
  assign issue    = (state_q == StScan) && !freeze;
  assign finish   = (state_q == StDrain) && !s1_valid_q && (!pend_valid_q || out_free);
  assign thr_we   = s1_hit && !freeze && (kept_q < CntW'(MAX_PATTERN_LENGTH));

  always_comb begin
    tbl_req          = '0;
    tbl_req.wr_en    = in_accept && (operation_i == pfac_pkg::OP_WRITE);
    tbl_req.wr_row   = entry_row_i;
    tbl_req.wr_col   = entry_column_i;
    tbl_req.wr_value = entry_value_i;
    tbl_req.rd_en    = issue;
    tbl_req.rd_row   = is_spawn ? ({1'b0, pattern_count_q} + pfac_pkg::RowReqW'(1))
                                : {1'b0, sel_row};
    tbl_req.rd_col   = byte_q;
  end

  pfac_table #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tbl_req),
    .rd_data_o(tbl_rd_data),
    .ready_o  (tbl_ready)
  );

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    live_count_d = live_count_q;
    idx_d        = idx_q;
    kept_d       = kept_q;
    s1_valid_d   = s1_valid_q;
    pend_valid_d = pend_valid_q;
    pend_start_d = pend_start_q;
    pend_row_d   = pend_row_q;
    out_valid_d  = out_valid_q;
    out_start_d  = out_start_q;
    out_row_d    = out_row_q;
    out_last_d   = out_last_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (!freeze) begin
      s1_valid_d = issue;
    end

    if (thr_we) begin
      kept_d = kept_q + CntW'(1);
    end

    if (s1_emit && !freeze) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_start_d = pend_start_q;
        out_row_d   = pend_row_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_start_d = s1_start_q;
      pend_row_d   = s1_next;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept && (operation_i == pfac_pkg::OP_SCAN)) begin
          idx_d   = '0;
          kept_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (issue) begin
          if (is_spawn) begin
            state_d = StDrain;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      StDrain: begin
        if (finish) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_start_d  = pend_start_q;
            out_row_d    = pend_row_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
          end
          if (last_q) begin
            live_count_d = '0;
            pos_d        = '0;
          end else begin
            live_count_d = kept_q;
            pos_d        = pos_q + pfac_pkg::pos_t'(1);
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      pattern_count_q <= '0;
      pos_q           <= '0;
      live_count_q    <= '0;
      idx_q           <= '0;
      kept_q          <= '0;
      s1_valid_q      <= 1'b0;
      pend_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      live_count_q <= live_count_d;
      idx_q        <= idx_d;
      kept_q       <= kept_d;
      s1_valid_q   <= s1_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        pattern_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_start_q <= pend_start_d;
    pend_row_q   <= pend_row_d;
    out_start_q  <= out_start_d;
    out_row_q    <= out_row_d;
    out_last_q   <= out_last_d;
    if (in_accept) begin
      byte_q <= text_byte_i;
      last_q <= last_byte_i;
    end
    if (issue) begin
      s1_start_q <= sel_start;
      s1_skip_q  <= sel_drop;
    end
    // Survivors are packed down in place; the write slot never passes the
    // slot that is read next.
    if (thr_we) begin
      thr_row_q[kept_q[IdxW-1:0]]   <= s1_next;
      thr_start_q[kept_q[IdxW-1:0]] <= s1_start_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_start_o = out_start_q;
  assign match_row_o   = out_row_q;
  assign last_match_o  = out_last_q;

  // Between text bytes nothing is left in flight or held back.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!s1_valid_q && !pend_valid_q))
    else $error("lookup or held match left over in idle");

  // Packing never overtakes the thread being looked up.
  a_pack_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (kept_q <= idx_q))
    else $error("thread packing overtook the lookup");

  // A held walk does not move on to the next thread.
  a_freeze_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freeze |=> ($stable(idx_q) && $stable(kept_q)))
    else $error("walk moved while the output was full");

  // The byte that ends the text clears threads and position.
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && last_q) |=> ((pos_q == '0) && (live_count_q == '0)))
    else $error("end of text did not clear the threads");

endmodule

### src/pfac_table.sv
// ----------------------------------------------------------------------------
// pfac_table
// Transition table memory with a clearing sweep after reset and range checks.
// ----------------------------------------------------------------------------
module pfac_table #(
  parameter int unsigned TABLE_ROWS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfac_pkg::tbl_req_t req_i,
  output pfac_pkg::ptr_t     rd_data_o,
  output logic               ready_o
);

  // Rows above the pointer range can never be written, so they always read zero.
  localparam int unsigned MemRows = (TABLE_ROWS < (2 ** pfac_pkg::PtrW)) ?
                                    TABLE_ROWS : (2 ** pfac_pkg::PtrW);
  localparam int unsigned RowW    = $clog2(MemRows);
  localparam int unsigned AddrW   = RowW + pfac_pkg::ColW;
  localparam int unsigned Depth   = MemRows * pfac_pkg::NumCols;

  pfac_pkg::ptr_t mem_q [Depth];

  logic               clearing_q, clearing_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic               we;
  logic [AddrW-1:0]   waddr;
  pfac_pkg::ptr_t     wdata;
  logic               rd_in_range;
  logic [AddrW-1:0]   raddr;
  pfac_pkg::ptr_t     rd_q;
  logic               rd_zero_q;

  assign rd_in_range = req_i.rd_row < pfac_pkg::RowReqW'(MemRows);
  assign raddr       = {req_i.rd_row[RowW-1:0], req_i.rd_col};

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    we         = 1'b0;
    waddr      = {req_i.wr_row[RowW-1:0], req_i.wr_col};
    wdata      = req_i.wr_value;
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
      clr_d = clr_q + AddrW'(1);
      if (clr_q == AddrW'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (req_i.wr_en &&
                 ({1'b0, req_i.wr_row} < pfac_pkg::RowReqW'(MemRows))) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q      <= mem_q[raddr];
      rd_zero_q <= !rd_in_range;
    end
  end

  assign rd_data_o = rd_zero_q ? '0 : rd_q;
  assign ready_o   = !clearing_q;

endmodule

### dv/pfac_match_board_pkg.sv
// ----------------------------------------------------------------------------
// pfac_match_board_pkg
// Predicts the match items of the trie matcher and checks them as they arrive.
// ----------------------------------------------------------------------------
package pfac_match_board_pkg;

  import pfac_pkg::*;

  localparam int unsigned TableRows = 1024;
  localparam int unsigned MaxWalk   = 32;

  typedef struct packed {
    logic operation;
    ptr_t entry_row;
    col_t entry_column;
    ptr_t entry_value;
    col_t text_byte;
    logic last_byte;
  } pfac_item_t;

  typedef struct packed {
    pos_t start;
    ptr_t row;
    logic last;
  } pfac_match_t;

  class pfac_match_board;

    // Mirror of the transition table and of the walks in flight.
    bit [PtrW-1:0] next_row [TableRows][NumCols];
    bit [PtrW-1:0] pattern_count;
    bit [PtrW-1:0] walk_row [MaxWalk];
    pos_t          walk_start [MaxWalk];
    bit            walk_live [MaxWalk];
    pos_t          text_pos;

    pfac_match_t   pending_matches [$];
    int unsigned   mismatches;

    function ptr_t step_from(int unsigned row, col_t sym);
      if (row >= TableRows) return '0;
      return next_row[row][sym];
    endfunction

    function void note_match(pos_t start, ptr_t row);
      pfac_match_t m;
      m.start = start;
      m.row   = row;
      m.last  = 1'b0;
      pending_matches.insert(pending_matches.size(), m);
    endfunction

    // Called once per accepted input item.
    task accept_item(pfac_item_t item);
      bit [PtrW-1:0] new_row [MaxWalk];
      pos_t          new_start [MaxWalk];
      int unsigned   kept;
      int unsigned   found;
      ptr_t          nxt;
      pos_t          age;
      kept  = 0;
      found = 0;
      if (item.operation == OP_WRITE) begin
        next_row[item.entry_row][item.entry_column] = item.entry_value;
        return;
      end
      // Older walks first, then the walk that starts at this byte.
      for (int i = 0; i < MaxWalk; i++) begin
        age = text_pos - walk_start[i];
        if (walk_live[i] && age < MaxWalk) begin
          nxt = step_from(walk_row[i], item.text_byte);
          if (nxt != 0) begin
            if (nxt <= pattern_count) begin
              note_match(walk_start[i], nxt);
              found++;
            end
            if (kept < MaxWalk) begin
              new_row[kept]   = nxt;
              new_start[kept] = walk_start[i];
              kept++;
            end
          end
        end
      end
      nxt = step_from(32'(pattern_count) + 1, item.text_byte);
      if (nxt != 0) begin
        if (nxt <= pattern_count) begin
          note_match(text_pos, nxt);
          found++;
        end
        if (kept < MaxWalk) begin
          new_row[kept]   = nxt;
          new_start[kept] = text_pos;
          kept++;
        end
      end
      if (found != 0) pending_matches[pending_matches.size()-1].last = 1'b1;
      for (int i = 0; i < MaxWalk; i++) begin
        walk_live[i]  = 1'b0;
        walk_row[i]   = '0;
        walk_start[i] = '0;
      end
      if (item.last_byte) begin
        text_pos = '0;
      end else begin
        for (int i = 0; i < kept; i++) begin
          walk_row[i]   = new_row[i];
          walk_start[i] = new_start[i];
          walk_live[i]  = 1'b1;
        end
        text_pos = text_pos + 1;
      end
    endtask

    // Every mismatch prints one line and is counted.
    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_match(pos_t start, ptr_t row, logic last);
      pfac_match_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("match start %0d row %0d with none pending", start, row));
        return;
      end
      want = pending_matches.pop_front();
      if (start !== want.start)
        report_mismatch($sformatf("match_start %0d, predicted %0d", start, want.start));
      if (row !== want.row)
        report_mismatch($sformatf("match_row %0d, predicted %0d", row, want.row));
      if (last !== want.last)
        report_mismatch($sformatf("last_match %b, predicted %b (start %0d row %0d)",
                                  last, want.last, want.start, want.row));
    endtask

    task report_leftovers();
      pfac_match_t want;
      while (pending_matches.size() != 0) begin
        want = pending_matches.pop_front();
        report_mismatch($sformatf("match start %0d row %0d never came", want.start, want.row));
      end
    endtask

  endclass

endpackage

### dv/pfac_multi_pattern_matcher_tb.sv
// ----------------------------------------------------------------------------
// pfac_multi_pattern_matcher_tb
// Self-checking bench for the failureless trie matcher. It loads pattern tries
// into the transition table through write items, scans text bytes and checks
// every match item against a predictor of the walks, under several settings
// of pattern_count and several patterns of source idling and sink stalls.
// ----------------------------------------------------------------------------
module pfac_multi_pattern_matcher_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pfac_pkg::*;
  import pfac_match_board_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  // This covers a scan with no match that may still be running when the last
  // predicted match has come out.
  localparam int unsigned SettleCycles  = 48;
  // Length of the long sink hold-off used to back the block up.
  localparam int unsigned HoldCycles    = 400;
  // The table clear after reset passes with no item accepted, so the limit on
  // quiet cycles sits well above the length of that clear.
  localparam int unsigned WatchdogLimit = 1500000;

  logic clk_i          = 1'b0;
  logic rst_ni         = 1'b0;
  logic cfg_we_i       = 1'b0;
  ptr_t cfg_wdata_i    = '0;
  logic in_valid_i     = 1'b0;
  logic in_stall_o;
  logic operation_i    = OP_WRITE;
  ptr_t entry_row_i    = '0;
  col_t entry_column_i = '0;
  ptr_t entry_value_i  = '0;
  col_t text_byte_i    = '0;
  logic last_byte_i    = 1'b0;
  logic out_valid_o;
  logic out_stall_i    = 1'b0;
  pos_t match_start_o;
  ptr_t match_row_o;
  logic last_match_o;

  // Idling controls, written by the main sequence only.
  int unsigned sender_gap_pct = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned hold_requests  = 0;

  // Owned by the sink process.
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  int unsigned quiet_cycles = 0;
  col_t        alphabet [4];

  pfac_match_board board;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  pfac_multi_pattern_matcher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .entry_row_i    (entry_row_i),
    .entry_column_i (entry_column_i),
    .entry_value_i  (entry_value_i),
    .text_byte_i    (text_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_start_o  (match_start_o),
    .match_row_o    (match_row_o),
    .last_match_o   (last_match_o)
  );

  // Sink side. A new hold request from the main sequence starts a long stall
  // that this process counts down on its own; otherwise the stall is random
  // at the rate of the current phase.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Match items are checked at the rising edge where they are taken. The same
  // edge feeds the watchdog, which restarts on any item moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_match(match_start_o, match_row_o, last_match_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Every field gets a random value; callers then pin the ones that matter,
  // so the fields an operation ignores still move around.
  function automatic pfac_item_t random_item();
    pfac_item_t item;
    item.operation    = 1'($urandom_range(1));
    item.entry_row    = ptr_t'($urandom_range((1 << PtrW) - 1));
    item.entry_column = col_t'($urandom_range(NumCols - 1));
    item.entry_value  = ptr_t'($urandom_range((1 << PtrW) - 1));
    item.text_byte    = col_t'($urandom_range(NumCols - 1));
    item.last_byte    = 1'($urandom_range(1));
    return item;
  endfunction

  // Offers one item and returns at the falling edge after it was taken, with
  // valid still high; the caller either drives the next item or drops valid
  // before the next rising edge.
  task automatic send_item(input pfac_item_t item);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    operation_i    = item.operation;
    entry_row_i    = item.entry_row;
    entry_column_i = item.entry_column;
    entry_value_i  = item.entry_value;
    text_byte_i    = item.text_byte;
    last_byte_i    = item.last_byte;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.accept_item(item);
    @(negedge clk_i);
  endtask

  task automatic write_entry(input int unsigned row, input int unsigned col,
                             input int unsigned value);
    pfac_item_t item;
    item              = random_item();
    item.operation    = OP_WRITE;
    item.entry_row    = ptr_t'(row);
    item.entry_column = col_t'(col);
    item.entry_value  = ptr_t'(value);
    send_item(item);
  endtask

  task automatic scan_byte(input int unsigned sym, input bit last);
    pfac_item_t item;
    item           = random_item();
    item.operation = OP_SCAN;
    item.text_byte = col_t'(sym);
    item.last_byte = last;
    send_item(item);
  endtask

  // Drains all predicted matches, then lets a scan with no match finish.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (board.pending_matches.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_pattern_count(input int unsigned count);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = ptr_t'(count);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    board.pattern_count = ptr_t'(count);
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    sender_gap_pct = gap_pct;
    rx_stall_pct   = stall_pct;
  endtask

  task automatic pick_alphabet();
    foreach (alphabet[k]) alphabet[k] = col_t'($urandom_range(NumCols - 1));
  endtask

  // Loads a handful of short patterns over the phase alphabet. Interior nodes
  // come from free rows above the start row; when none are left, a pattern-end
  // row is reused as an interior node, so one pattern becomes a prefix of
  // another. With no pattern-end rows the last step goes to a plain row and
  // nothing can match.
  task automatic build_patterns(input int unsigned count, input int unsigned npat);
    int unsigned start_row;
    int unsigned fresh;
    int unsigned row;
    int unsigned nxt;
    int unsigned len;
    col_t        sym;
    start_row = count + 1;
    if (start_row >= TableRows) return;
    fresh = count + 2;
    repeat (npat) begin
      row = start_row;
      len = $urandom_range(4, 1);
      for (int j = 0; j < len; j++) begin
        sym = alphabet[$urandom_range(3)];
        if (j == len - 1) begin
          nxt = (count == 0) ? $urandom_range(TableRows - 1, 2) : $urandom_range(count, 1);
          write_entry(row, sym, nxt);
        end else begin
          nxt = board.next_row[row][sym];
          if (nxt == 0) begin
            if (fresh < TableRows) begin
              nxt = fresh;
              fresh++;
            end else if (count != 0) begin
              nxt = $urandom_range(count, 1);
            end else begin
              nxt = $urandom_range(TableRows - 1, 2);
            end
            write_entry(row, sym, nxt);
          end
          row = nxt;
        end
      end
    end
  endtask

  // Mostly scans over the phase alphabet, some stray bytes and some writes of
  // random entries anywhere in the table; texts end now and then.
  task automatic scan_text(input int unsigned nitems);
    pfac_item_t item;
    repeat (nitems) begin
      item = random_item();
      if ($urandom_range(99) < 12) begin
        item.operation = OP_WRITE;
      end else begin
        item.operation = OP_SCAN;
        if ($urandom_range(99) < 75) item.text_byte = alphabet[$urandom_range(3)];
        item.last_byte = ($urandom_range(9) == 0);
      end
      send_item(item);
    end
  endtask

  initial begin
    col_t loop_sym;
    board = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with three patterns: start row 4, a single-byte pattern
    // on 0x41 whose end row loops to itself on 0x41, a pattern over the byte
    // extremes 0x00 0xFF, and one that passes through row 1023. The block is
    // still clearing its table here, so the first items wait on in_stall_o.
    set_idling(0, 0);
    set_pattern_count(3);
    write_entry(4, 8'h41, 1);
    write_entry(1, 8'h41, 1);
    write_entry(4, 8'h00, 5);
    write_entry(5, 8'hFF, 2);
    write_entry(4, 8'h80, 1023);
    write_entry(1023, 8'h7F, 3);
    write_entry(0, 8'h00, 0);
    scan_byte(8'h41, 1'b0);  // single-byte match at position 0
    scan_byte(8'h41, 1'b0);  // old walk and new walk both match
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);  // two-byte pattern starting at 2
    scan_byte(8'h80, 1'b0);
    scan_byte(8'h7F, 1'b1);  // pattern through row 1023, text ends
    scan_byte(8'h41, 1'b1);  // position is back at 0
    scan_byte(8'h55, 1'b0);  // nothing matches
    scan_byte(8'hFF, 1'b1);

    // No pattern-end rows at all: walks run but never report.
    set_pattern_count(0);
    set_idling(80, 0);
    pick_alphabet();
    build_patterns(0, 6);
    scan_text(15);

    // A single pattern that repeats on one byte. A long run of that byte
    // keeps every walk alive until the length limit drops it, so each byte
    // reports as many matches as walks are allowed. The sink holds off for a
    // long stretch meanwhile, so the block fills up and stalls its input.
    set_pattern_count(1);
    set_idling(0, 0);
    pick_alphabet();
    loop_sym = alphabet[0];
    write_entry(2, loop_sym, 1);
    write_entry(1, loop_sym, 1);
    hold_requests++;
    repeat (40) scan_byte(loop_sym, 1'b0);
    scan_byte(loop_sym, 1'b1);
    scan_text(10);

    // A few patterns with a busy sink.
    set_pattern_count($urandom_range(12, 2));
    set_idling(0, 80);
    pick_alphabet();
    build_patterns(board.pattern_count, 10);
    scan_text(35);

    // Widest usable count: start row 1023, every row below it is a pattern end.
    set_pattern_count(1022);
    set_idling(29, 29);
    pick_alphabet();
    build_patterns(1022, 12);
    scan_text(30);

    // Start row beyond the table: new walks always fail, old ones go on.
    set_pattern_count(1023);
    set_idling(80, 0);
    scan_text(15);

    // A larger pattern set with idling on both sides.
    set_pattern_count($urandom_range(40, 5));
    set_idling(29, 29);
    pick_alphabet();
    build_patterns(board.pattern_count, 14);
    scan_text(45);

    wait_idle();
    board.report_leftovers();
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/pfac_pkg.sv
src/pfac_table.sv
src/pfac_multi_pattern_matcher.sv
dv/pfac_match_board_pkg.sv
dv/pfac_multi_pattern_matcher_tb.sv
